@@ src/efbt_pkg.sv @@
`timescale 1ns / 1ps

package efbt_pkg;

    // Field widths of one transaction
    localparam int SLOT_FIELD_W = 3;
    localparam int ANGLE_W      = 13;
    localparam int SPEED_W      = 16;
    localparam int RATE_W       = 14;
    localparam int TURN_W       = 24;
    localparam int POS_W        = 37;

    // Shared adder width: wide enough for the total position
    localparam int ALU_W = POS_W;

    // Stream widths
    localparam int IN_TDATA_W  = SLOT_FIELD_W + ANGLE_W + SPEED_W;
    localparam int OUT_FIELD_W = 3 * RATE_W + TURN_W + POS_W + SPEED_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Default configuration
    localparam int DEF_MOTOR_SLOTS     = 5;
    localparam int DEF_WINDOW_LEN      = 5;
    localparam int DEF_COUNTS_PER_TURN = 8192;
    localparam int DEF_TRIGGER_RATIO   = 36;

    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_DIFF,
        ST_WRAP,
        ST_TURN,
        ST_SUB_OLD,
        ST_ADD_NEW,
        ST_ABS,
        ST_DIV,
        ST_NEG,
        ST_MUL,
        ST_POS_ANGLE,
        ST_POS_OFFSET,
        ST_OUT
    } efbt_state_t;

endpackage

@@ src/efbt_alu.sv @@
`timescale 1ns / 1ps

module efbt_alu import efbt_pkg::*;
(
    input  alu_op_t                  op,
    input  logic signed [ALU_W-1:0]  a,
    input  logic signed [ALU_W-1:0]  b,
    output logic signed [ALU_W-1:0]  y
);

    // Add or subtract the two operands
    always_comb
    begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

@@ src/efbt_hist_ram.sv @@
`timescale 1ns / 1ps

module efbt_hist_ram import efbt_pkg::*;
#(
    parameter int ADDR_W = 6,
    parameter int DATA_W = RATE_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_data_reg;

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Mark written entries; a cleared entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/encoder_feedback_tracker_core.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Group                     Content
// s_axis    in         s_tvalid/s_tready/s_tdata motor_slot, angle_raw, speed_word
//                      s_tuser                   is_trigger
// m_axis    out        m_tvalid/m_tready/m_tdata rates, turn count, position, speed
// cfg       in         cfg_we/cfg_wdata          encoder_offset
//
// One transaction in range runs from acceptance back to idle through these steps:
// the steps on the shared adder, one reciprocal-multiply divide pass per divisor
// (the trigger motor adds the gear ratio as a divisor), a multiply for the position,
// the load of the output register and the return to idle. An out-of-range slot is
// taken while idle and gives no result.
// Reset clears all per-slot tracking state and the offset at once; history
// entries read as zero until written. A stalled result waits in the output
// register; the block takes the next item as soon as the result is loaded.

module encoder_feedback_tracker_core import efbt_pkg::*;
#(
    parameter int MOTOR_SLOTS     = DEF_MOTOR_SLOTS,
    parameter int WINDOW_LEN      = DEF_WINDOW_LEN,
    parameter int COUNTS_PER_TURN = DEF_COUNTS_PER_TURN,
    parameter int TRIGGER_RATIO   = DEF_TRIGGER_RATIO
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // motor_slot [2:0], angle_raw [15:3], speed_word [31:16]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // is_trigger [0]
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // raw_rate [13:0], filtered_rate [27:14], previous_filtered_rate [41:28],
    // turn_count [65:42], total_position [102:66], speed_echo [118:103], zero [119]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [ANGLE_W-1:0]     cfg_wdata
);

    localparam int SLOT_W   = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
    localparam int PTR_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int MAG_W    = $clog2(WINDOW_LEN * (2 ** (RATE_W - 1)) + 1);
    localparam int SUM_W    = MAG_W + 1;
    localparam int WIN_DW   = $clog2(WINDOW_LEN + 1);
    localparam int GEAR_DW  = $clog2(TRIGGER_RATIO + 1);
    localparam int WIN_SH   = MAG_W + WIN_DW;
    localparam int GEAR_SH  = MAG_W + GEAR_DW;
    localparam int WIN_RCP  = (2 ** WIN_SH + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int GEAR_RCP = (2 ** GEAR_SH + TRIGGER_RATIO - 1) / TRIGGER_RATIO;
    localparam int RCP_W    = $clog2(((WIN_RCP > GEAR_RCP) ? WIN_RCP : GEAR_RCP) + 1);
    localparam int QP_W     = MAG_W + RCP_W;
    localparam int CPT_W    = $clog2(COUNTS_PER_TURN + 1);
    localparam int PROD_W   = TURN_W + CPT_W + 1;

    localparam logic signed [ALU_W-1:0] HALF_S   = ALU_W'(COUNTS_PER_TURN / 2);
    localparam logic signed [ALU_W-1:0] CPT_S    = ALU_W'(COUNTS_PER_TURN);
    localparam logic signed [CPT_W:0]   CPT_MUL  = (CPT_W + 1)'(COUNTS_PER_TURN);

    efbt_state_t state_reg;
    efbt_state_t state_next;

    // Per-slot tracking state
    logic [ANGLE_W-1:0]       last_angle_reg [MOTOR_SLOTS];
    logic [TURN_W-1:0]        turns_reg      [MOTOR_SLOTS];
    logic [PTR_W-1:0]         ptr_reg        [MOTOR_SLOTS];
    logic signed [SUM_W-1:0]  sum_reg        [MOTOR_SLOTS];
    logic signed [RATE_W-1:0] lastf_reg      [MOTOR_SLOTS];

    logic [ANGLE_W-1:0]       offset_reg;

    // Item in work
    logic [SLOT_W-1:0]        slot_reg;
    logic [ANGLE_W-1:0]       angle_reg;
    logic [SPEED_W-1:0]       speed_reg;
    logic                     trig_reg;
    logic signed [ALU_W-1:0]  acc_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic signed [RATE_W-1:0] filt_reg;
    logic signed [RATE_W-1:0] prev_reg;
    logic                     up_reg;
    logic                     dn_reg;
    logic                     neg_reg;

    // Divider
    logic [MAG_W-1:0]         dvd_reg;
    logic [MAG_W-1:0]         quo_reg;
    logic                     pass_reg;
    logic [RCP_W-1:0]         rcp_sel;
    logic [QP_W-1:0]          quo_prod;
    logic [MAG_W-1:0]         quo_next;

    // Output register
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;

    // Shared adder
    alu_op_t                  alu_op;
    logic signed [ALU_W-1:0]  alu_a;
    logic signed [ALU_W-1:0]  alu_b;
    logic signed [ALU_W-1:0]  alu_y;

    logic                     in_ok;
    logic                     in_acc;
    logic [SLOT_W-1:0]        in_slot;
    logic                     wrap_hi;
    logic                     wrap_lo;
    logic                     out_free;
    logic signed [PROD_W-1:0] prod;
    logic [RATE_W-1:0]        old_rate;
    logic [PTR_W-1:0]         cur_ptr;

    efbt_alu u_alu
    (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    efbt_hist_ram
    #(
        .ADDR_W (SLOT_W + PTR_W),
        .DATA_W (RATE_W)
    )
    u_hist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr ({in_slot, ptr_reg[in_slot]}),
        .rd_data (old_rate),
        .wr_en   (state_reg == ST_ADD_NEW),
        .wr_addr ({slot_reg, cur_ptr}),
        .wr_data (rate_reg)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_ok    = (32'(s_tdata[SLOT_FIELD_W-1:0]) < MOTOR_SLOTS);
    assign in_acc   = s_tvalid && s_tready && in_ok;
    assign in_slot  = in_ok ? SLOT_W'(s_tdata[SLOT_FIELD_W-1:0]) : '0;
    assign cur_ptr  = ptr_reg[slot_reg];
    assign out_free = !m_tvalid_reg || m_tready;

    assign wrap_hi  = (acc_reg > HALF_S);
    assign wrap_lo  = (acc_reg < -HALF_S);

    // One divide pass: multiply the magnitude by the scaled reciprocal, keep the high bits
    assign rcp_sel  = pass_reg ? RCP_W'(GEAR_RCP) : RCP_W'(WIN_RCP);
    assign quo_prod = QP_W'(dvd_reg) * QP_W'(rcp_sel);
    assign quo_next = pass_reg ? MAG_W'(quo_prod >> GEAR_SH) : MAG_W'(quo_prod >> WIN_SH);

    assign prod = $signed(turns_reg[slot_reg]) * CPT_MUL;

    // Sequence the steps and steer the shared adder
    always_comb
    begin
        state_next = state_reg;
        alu_op     = ALU_ADD;
        alu_a      = acc_reg;
        alu_b      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                alu_op     = ALU_SUB;
                alu_a      = ALU_W'(angle_reg);
                alu_b      = ALU_W'(last_angle_reg[slot_reg]);
                state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                alu_op     = wrap_hi ? ALU_SUB : ALU_ADD;
                alu_b      = (wrap_hi || wrap_lo) ? CPT_S : '0;
                state_next = ST_TURN;
            end
            ST_TURN:
            begin
                alu_op     = dn_reg ? ALU_SUB : ALU_ADD;
                alu_a      = ALU_W'(turns_reg[slot_reg]);
                alu_b      = ALU_W'(up_reg || dn_reg);
                state_next = ST_SUB_OLD;
            end
            ST_SUB_OLD:
            begin
                alu_op     = ALU_SUB;
                alu_a      = ALU_W'(sum_reg[slot_reg]);
                alu_b      = ALU_W'($signed(old_rate));
                state_next = ST_ADD_NEW;
            end
            ST_ADD_NEW:
            begin
                alu_b      = ALU_W'(rate_reg);
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                alu_op     = neg_reg ? ALU_SUB : ALU_ADD;
                alu_a      = '0;
                alu_b      = acc_reg;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (pass_reg || !trig_reg)
                begin
                    state_next = ST_NEG;
                end
            end
            ST_NEG:
            begin
                alu_op     = neg_reg ? ALU_SUB : ALU_ADD;
                alu_a      = '0;
                alu_b      = ALU_W'(quo_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_POS_ANGLE;
            end
            ST_POS_ANGLE:
            begin
                alu_b      = ALU_W'(angle_reg);
                state_next = ST_POS_OFFSET;
            end
            ST_POS_OFFSET:
            begin
                alu_op     = ALU_SUB;
                alu_b      = ALU_W'(offset_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the offset written over the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            offset_reg <= cfg_wdata;
        end
    end

    // Per-slot state: update as the steps complete
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTOR_SLOTS; i++)
            begin
                last_angle_reg[i] <= '0;
                turns_reg[i]      <= '0;
                ptr_reg[i]        <= '0;
                sum_reg[i]        <= '0;
                lastf_reg[i]      <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_TURN:
                begin
                    turns_reg[slot_reg] <= TURN_W'(alu_y);
                end
                ST_ADD_NEW:
                begin
                    sum_reg[slot_reg]        <= SUM_W'(alu_y);
                    last_angle_reg[slot_reg] <= angle_reg;
                    ptr_reg[slot_reg]        <= (cur_ptr == PTR_W'(WINDOW_LEN - 1)) ?
                                                '0 : cur_ptr + 1'b1;
                end
                ST_NEG:
                begin
                    lastf_reg[slot_reg] <= RATE_W'(alu_y);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers of the item in flight
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    slot_reg  <= in_slot;
                    angle_reg <= s_tdata[SLOT_FIELD_W +: ANGLE_W];
                    speed_reg <= s_tdata[SLOT_FIELD_W + ANGLE_W +: SPEED_W];
                    trig_reg  <= s_tuser;
                end
            end
            ST_DIFF:
            begin
                acc_reg <= alu_y;
            end
            ST_WRAP:
            begin
                rate_reg <= RATE_W'(alu_y);
                up_reg   <= wrap_lo;
                dn_reg   <= wrap_hi;
            end
            ST_SUB_OLD:
            begin
                acc_reg <= alu_y;
            end
            ST_ADD_NEW:
            begin
                acc_reg <= alu_y;
                neg_reg <= alu_y[ALU_W-1];
            end
            ST_ABS:
            begin
                dvd_reg  <= MAG_W'(alu_y);
                pass_reg <= 1'b0;
            end
            ST_DIV:
            begin
                // the magnitude path makes the quotient truncate toward zero
                quo_reg <= quo_next;
                if (!pass_reg && trig_reg)
                begin
                    // second pass divides the window mean by the gear ratio
                    dvd_reg  <= quo_next;
                    pass_reg <= 1'b1;
                end
            end
            ST_NEG:
            begin
                filt_reg <= RATE_W'(alu_y);
                prev_reg <= lastf_reg[slot_reg];
            end
            ST_MUL:
            begin
                acc_reg <= ALU_W'(prod);
            end
            ST_POS_ANGLE:
            begin
                acc_reg <= alu_y;
            end
            ST_POS_OFFSET:
            begin
                acc_reg <= alu_y;
            end
            default:
            begin
            end
        endcase
    end

    // Output register: load the result, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= {OUT_PAD_W'(0), speed_reg, POS_W'(acc_reg),
                            turns_reg[slot_reg], prev_reg, filt_reg, rate_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ src/efbt_checker.sv @@
`timescale 1ns / 1ps

module efbt_checker import efbt_pkg::*;
#(
    parameter int MOTOR_SLOTS = DEF_MOTOR_SLOTS
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic in_rng;

    assign in_rng = (32'(s_tdata[SLOT_FIELD_W-1:0]) < MOTOR_SLOTS);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A tracked transaction keeps the block busy for its steps
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && in_rng |=> !s_tready ##1 !s_tready)
        else $error("ready returned before the item was processed");

    // A transaction for an unknown slot is dropped at once
    a_skip: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !in_rng |=> s_tready && !$rose(m_tvalid))
        else $error("out-of-range slot was processed");

    // A new result only follows a busy period
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

endmodule

bind encoder_feedback_tracker_core efbt_checker
#(
    .MOTOR_SLOTS (MOTOR_SLOTS)
)
u_efbt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
